### rtl/core/qte_pkg.sv
package qte_pkg;

	localparam int OPW        = 34;
	localparam int SW         = 32;
	localparam int SQW        = 62;
	localparam int RTW        = 31;
	localparam int AW         = 36;
	localparam int ZW         = 32;
	localparam int TAB_LEN    = 24;
	localparam int SQRT_STEPS = 31;

	typedef struct packed {
		logic signed [SW-1:0]  s;
		logic                  clamp;
		logic signed [OPW-1:0] yn;
		logic signed [OPW-1:0] yd;
		logic signed [OPW-1:0] rn;
		logic signed [OPW-1:0] rd;
	} ops_t;

	function automatic logic signed [ZW-1:0] atan_tab(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0:  v = 32'sd47185920;
			1:  v = 32'sd27855475;
			2:  v = 32'sd14718068;
			3:  v = 32'sd7471121;
			4:  v = 32'sd3750058;
			5:  v = 32'sd1876857;
			6:  v = 32'sd938658;
			7:  v = 32'sd469357;
			8:  v = 32'sd234682;
			9:  v = 32'sd117342;
			10: v = 32'sd58671;
			11: v = 32'sd29335;
			12: v = 32'sd14668;
			13: v = 32'sd7334;
			14: v = 32'sd3667;
			15: v = 32'sd1833;
			16: v = 32'sd917;
			17: v = 32'sd458;
			18: v = 32'sd229;
			19: v = 32'sd115;
			20: v = 32'sd57;
			21: v = 32'sd29;
			22: v = 32'sd14;
			23: v = 32'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### rtl/core/qte_front.sv
module qte_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               vld,
	output logic [qte_pkg::SQW-1:0] sq,
	output qte_pkg::ops_t      ops
);

	localparam logic signed [qte_pkg::OPW-1:0] ONE = 34'sd1073741824;

	logic v_s1, v_s2;
	logic signed [31:0] xy_s1, zw_s1, yw_s1, xz_s1, xw_s1, yz_s1, xx_s1, yy_s1, zz_s1;
	qte_pkg::ops_t ops_s2;
	logic [qte_pkg::RTW-1:0] mag_s2;

	logic signed [qte_pkg::OPW-1:0] s_raw;
	logic signed [qte_pkg::SW-1:0]  s_c;
	logic                           clamp;
	logic [qte_pkg::RTW-1:0]        mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vld  <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			vld  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		xy_s1 <= quat_x * quat_y;
		zw_s1 <= quat_z * quat_w;
		yw_s1 <= quat_y * quat_w;
		xz_s1 <= quat_x * quat_z;
		xw_s1 <= quat_x * quat_w;
		yz_s1 <= quat_y * quat_z;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		zz_s1 <= quat_z * quat_z;
	end

	always_comb begin
		s_raw = (34'(xy_s1) + 34'(zw_s1)) <<< 1;
		clamp = 1'b0;
		if (s_raw > ONE) begin
			s_c   = 32'sd1073741824;
			clamp = 1'b1;
		end else if (s_raw < -ONE) begin
			s_c   = -32'sd1073741824;
			clamp = 1'b1;
		end else begin
			s_c = s_raw[qte_pkg::SW-1:0];
		end
		mag = s_c[qte_pkg::SW-1] ? qte_pkg::RTW'(-s_c) : qte_pkg::RTW'(s_c);
	end

	always_ff @(posedge clk) begin
		ops_s2.s     <= s_c;
		ops_s2.clamp <= clamp;
		ops_s2.yn    <= (34'(yw_s1) - 34'(xz_s1)) <<< 1;
		ops_s2.yd    <= ONE - ((34'(yy_s1) + 34'(zz_s1)) <<< 1);
		ops_s2.rn    <= (34'(xw_s1) - 34'(yz_s1)) <<< 1;
		ops_s2.rd    <= ONE - ((34'(xx_s1) + 34'(zz_s1)) <<< 1);
		mag_s2       <= mag;
		sq           <= qte_pkg::SQW'(mag_s2) * qte_pkg::SQW'(mag_s2);
		ops          <= ops_s2;
	end

endmodule

### rtl/core/qte_isqrt.sv
module qte_isqrt #(
	parameter int PW = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  logic [qte_pkg::SQW-1:0] in_sq,
	input  logic [PW-1:0]           in_pay,
	output logic                    out_vld,
	output logic [qte_pkg::RTW-1:0] out_root,
	output logic [PW-1:0]           out_pay
);

	localparam int N = qte_pkg::SQRT_STEPS;
	localparam logic [qte_pkg::SQW-1:0] ONE60 = qte_pkg::SQW'(1) << 60;

	logic [qte_pkg::SQW-1:0] rem_s  [0:N];
	logic [qte_pkg::SQW-1:0] root_s [0:N];
	logic [PW-1:0]           pay_s  [0:N];
	logic                    vld_s  [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= ONE60 - in_sq;
		root_s[0] <= '0;
		pay_s[0]  <= in_pay;
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [qte_pkg::SQW-1:0] B = qte_pkg::SQW'(1) << (60 - 2 * k);
		logic [qte_pkg::SQW-1:0] trial;
		assign trial = root_s[k] + B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			pay_s[k+1] <= pay_s[k];
			if (rem_s[k] >= trial) begin
				rem_s[k+1]  <= rem_s[k] - trial;
				root_s[k+1] <= (root_s[k] >> 1) + B;
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k] >> 1;
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = root_s[N][qte_pkg::RTW-1:0];
	assign out_pay  = pay_s[N];

endmodule

### rtl/core/qte_cordic.sv
module qte_cordic #(
	parameter int ITER = 16,
	parameter int OW   = 16,
	parameter int LIM  = 23040
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  logic signed [qte_pkg::OPW-1:0] in_n,
	input  logic signed [qte_pkg::OPW-1:0] in_d,
	input  logic                           in_tag,
	output logic                           out_vld,
	output logic signed [OW-1:0]           out_ang,
	output logic                           out_tag
);

	localparam int N  = (ITER > qte_pkg::TAB_LEN) ? qte_pkg::TAB_LEN : ITER;
	localparam int AW = qte_pkg::AW;
	localparam int ZW = qte_pkg::ZW;
	localparam logic signed [ZW-1:0] DEG90 = 32'sd94371840;
	localparam logic signed [ZW-1:0] LIMV  = ZW'(LIM);

	logic signed [AW-1:0] x_s [0:N];
	logic signed [AW-1:0] y_s [0:N];
	logic signed [ZW-1:0] z_s [0:N];
	logic                 zero_s [0:N];
	logic                 tag_s  [0:N];
	logic                 vld_s  [0:N];

	logic signed [AW-1:0] n_e, d_e, x0, y0;
	logic signed [ZW-1:0] z0, q;

	always_comb begin
		n_e = AW'(in_n);
		d_e = AW'(in_d);
		x0  = d_e;
		y0  = n_e;
		z0  = '0;
		if (d_e < 0) begin
			if (n_e >= 0) begin
				x0 = n_e;
				y0 = -d_e;
				z0 = DEG90;
			end else begin
				x0 = -n_e;
				y0 = d_e;
				z0 = -DEG90;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= x0;
		y_s[0]    <= y0;
		z_s[0]    <= z0;
		zero_s[0] <= (in_n == '0) && (in_d == '0);
		tag_s[0]  <= in_tag;
	end

	for (genvar k = 0; k < N; k++) begin : g_iter
		localparam logic signed [ZW-1:0] A = qte_pkg::atan_tab(k);
		logic signed [AW-1:0] xs, ys;
		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			zero_s[k+1] <= zero_s[k];
			tag_s[k+1]  <= tag_s[k];
			if (y_s[k] >= 0) begin
				x_s[k+1] <= x_s[k] + ys;
				y_s[k+1] <= y_s[k] - xs;
				z_s[k+1] <= z_s[k] + A;
			end else begin
				x_s[k+1] <= x_s[k] - ys;
				y_s[k+1] <= y_s[k] + xs;
				z_s[k+1] <= z_s[k] - A;
			end
		end
	end

	assign q = (z_s[N] + 32'sd4096) >>> 13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		out_tag <= tag_s[N];
		if (zero_s[N]) begin
			out_ang <= '0;
		end else if (q > LIMV) begin
			out_ang <= OW'(LIMV);
		end else if (q < -LIMV) begin
			out_ang <= OW'(-LIMV);
		end else begin
			out_ang <= OW'(q);
		end
	end

endmodule

### rtl/core/quaternion_to_euler_degrees_core.sv
// The path from start to done is set by the product stages,
// one square-root stage per root bit and one per CORDIC step.
// Throughput: one quaternion per cycle; busy stays low and every stage advances each cycle.
// Results appear for one cycle with done; the receiver cannot stall.
// Reset clears the valid bits only; data registers are not reset.
module quaternion_to_euler_degrees_core #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               done,
	output logic signed [14:0] pitch_deg,
	output logic signed [15:0] yaw_deg,
	output logic signed [15:0] roll_deg,
	output logic               asin_clamped
);

	localparam int PW = $bits(qte_pkg::ops_t);

	logic                    f_vld, r_vld;
	logic [qte_pkg::SQW-1:0] f_sq;
	qte_pkg::ops_t           f_ops, r_ops;
	logic [qte_pkg::RTW-1:0] r_root;
	logic [PW-1:0]           r_pay;

	assign busy  = 1'b0;
	assign r_ops = qte_pkg::ops_t'(r_pay);

	qte_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.quat_w (quat_w),
		.vld    (f_vld),
		.sq     (f_sq),
		.ops    (f_ops)
	);

	qte_isqrt #(.PW(PW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (f_vld),
		.in_sq    (f_sq),
		.in_pay   (PW'(f_ops)),
		.out_vld  (r_vld),
		.out_root (r_root),
		.out_pay  (r_pay)
	);

	qte_cordic #(.ITER(CORDIC_ITERATIONS), .OW(15), .LIM(11520)) u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (r_vld),
		.in_n    (qte_pkg::OPW'(r_ops.s)),
		.in_d    ($signed({3'b000, r_root})),
		.in_tag  (r_ops.clamp),
		.out_vld (done),
		.out_ang (pitch_deg),
		.out_tag (asin_clamped)
	);

	qte_cordic #(.ITER(CORDIC_ITERATIONS), .OW(16), .LIM(23040)) u_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (r_vld),
		.in_n    (r_ops.yn),
		.in_d    (r_ops.yd),
		.in_tag  (1'b0),
		.out_vld (),
		.out_ang (yaw_deg),
		.out_tag ()
	);

	qte_cordic #(.ITER(CORDIC_ITERATIONS), .OW(16), .LIM(23040)) u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (r_vld),
		.in_n    (r_ops.rn),
		.in_d    (r_ops.rd),
		.in_tag  (1'b0),
		.out_vld (),
		.out_ang (roll_deg),
		.out_tag ()
	);

endmodule

### tb/sv/tb_quaternion_to_euler_degrees_core.sv
`timescale 1ns / 1ps

module tb_quaternion_to_euler_degrees_core;

	localparam int ITERS     = 16;
	localparam int WD_LIMIT  = 4000;
	localparam int NO_CLAMP  = 2;

	typedef struct packed {
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic signed [15:0] roll;
		logic               clamp;
	} euler_t;

	typedef struct {
		logic signed [15:0] x, y, z, w;
		int                 clamp;
	} quat_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
	logic               done;
	logic signed [14:0] pitch_deg;
	logic signed [15:0] yaw_deg, roll_deg;
	logic               asin_clamped;

	int     typed_clamp;
	euler_t angles_q[$];
	int     errs;
	int     idle_pct;
	int     quiet;

	quaternion_to_euler_degrees_core #(.CORDIC_ITERATIONS(ITERS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
		.done(done), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg), .roll_deg(roll_deg),
		.asin_clamped(asin_clamped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(longint n, longint d);
		longint vx, vy, ang, t, xs, ys;
		vx = d;
		vy = n;
		ang = 0;
		if (n == 0 && d == 0)
			return 0;
		if (vx < 0) begin
			t = vx;
			if (vy >= 0) begin
				ang = 64'sd90 <<< 20;
				vx = vy;
				vy = -t;
			end else begin
				ang = -(64'sd90 <<< 20);
				vx = -vy;
				vy = t;
			end
		end
		for (int i = 0; i < ITERS && i < qte_pkg::TAB_LEN; i++) begin
			xs = vx >>> i;
			ys = vy >>> i;
			if (vy >= 0) begin
				vx = vx + ys;
				vy = vy - xs;
				ang += longint'(qte_pkg::atan_tab(i));
			end else begin
				vx = vx - ys;
				vy = vy + xs;
				ang -= longint'(qte_pkg::atan_tab(i));
			end
		end
		return ang;
	endfunction

	function automatic longint to_degrees(longint ang, longint lim);
		longint q;
		q = (ang + 4096) >>> 13;
		if (q > lim)
			q = lim;
		if (q < -lim)
			q = -lim;
		return q;
	endfunction

	function automatic euler_t predict_euler(longint qx, longint qy, longint qz, longint qw);
		euler_t          e;
		longint          s, c;
		longint unsigned mag;
		s = 2 * (qx * qy + qz * qw);
		e.clamp = 1'b0;
		if (s > (64'sd1 <<< 30)) begin
			s = 64'sd1 <<< 30;
			e.clamp = 1'b1;
		end else if (s < -(64'sd1 <<< 30)) begin
			s = -(64'sd1 <<< 30);
			e.clamp = 1'b1;
		end
		mag = (s < 0) ? -s : s;
		c = longint'(int_sqrt((64'd1 << 60) - mag * mag));
		e.pitch = 15'(to_degrees(vector_angle(s, c), 11520));
		e.yaw = 16'(to_degrees(vector_angle(2 * (qy * qw - qx * qz),
			(64'sd1 <<< 30) - 2 * (qy * qy + qz * qz)), 23040));
		e.roll = 16'(to_degrees(vector_angle(2 * (qx * qw - qy * qz),
			(64'sd1 <<< 30) - 2 * (qx * qx + qz * qz)), 23040));
		return e;
	endfunction

	always @(posedge clk) begin
		euler_t e, got;
		logic   moved;
		if (arst_n) begin
			moved = 1'b0;
			if (start && !busy) begin
				e = predict_euler(quat_x, quat_y, quat_z, quat_w);
				if (typed_clamp != NO_CLAMP)
					e.clamp = typed_clamp[0];
				angles_q.push_back(e);
				moved = 1'b1;
			end
			if (done) begin
				moved = 1'b1;
				got = '{pitch_deg, yaw_deg, roll_deg, asin_clamped};
				if (angles_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected transfer: %p", got);
				end else begin
					e = angles_q.pop_front();
					if (got !== e) begin
						errs++;
						if (errs <= 10)
							$display("mismatch: expected %p actual %p", e, got);
					end
				end
			end
			quiet <= moved ? 0 : quiet + 1;
			if (quiet >= WD_LIMIT) begin
				$display("tb_quaternion_to_euler_degrees_core: errors");
				$finish;
			end
		end
	end

	task automatic send_quat(logic signed [15:0] qx, qy, qz, qw, int tclamp);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		quat_x <= qx;
		quat_y <= qy;
		quat_z <= qz;
		quat_w <= qw;
		typed_clamp <= tclamp;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_comp(int scale);
		logic signed [15:0] v;
		v = 16'($urandom);
		return v >>> scale;
	endfunction

	quat_row_t directed[] = '{
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 0},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 0},
		'{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 0},
		'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1},
		'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1},
		'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1},
		'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1},
		'{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, NO_CLAMP},
		'{16'sd23170, -16'sd23170, 16'sd0, 16'sd0, NO_CLAMP},
		'{16'sd0, 16'sd16384, 16'sd16384, 16'sd0, NO_CLAMP},
		'{16'sd0, -16'sd32768, 16'sd0, 16'sd0, 0},
		'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 0},
		'{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 0},
		'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, NO_CLAMP},
		'{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, NO_CLAMP},
		'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 0},
		'{16'sd1, 16'sd1, 16'sd1, 16'sd1, 0},
		'{16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 0},
		'{16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 0},
		'{16'sh5555, -16'sh5556, 16'sh2AAA, 16'sh7FFF, NO_CLAMP}
	};

	initial begin
		int phase_pct[4];
		phase_pct = '{0, 83, 0, 22};
		arst_n = 1'b0;
		start = 1'b0;
		quat_x = '0;
		quat_y = '0;
		quat_z = '0;
		quat_w = '0;
		typed_clamp = NO_CLAMP;
		errs = 0;
		quiet = 0;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (directed[i])
			send_quat(directed[i].x, directed[i].y, directed[i].z, directed[i].w,
				directed[i].clamp);
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_pct[p];
			for (int k = 0; k < 410; k++) begin
				int sc;
				sc = ($urandom_range(1)) ? 0 : $urandom_range(3);
				send_quat(rand_comp(sc), rand_comp(sc), rand_comp(sc), rand_comp(sc),
					NO_CLAMP);
			end
		end
		start <= 1'b0;
		typed_clamp <= NO_CLAMP;
		while (angles_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errs == 0 && angles_q.size() == 0) begin
			$display("tb_quaternion_to_euler_degrees_core: clean");
		end else begin
			$display("tb_quaternion_to_euler_degrees_core: errors");
		end
		$finish;
	end

endmodule
